// File: rtl/tbs_pkg.sv
package tbs_pkg;

	// Field widths of the stream payloads
	localparam int MODE_W    = 1;
	localparam int TAG_W     = 16;
	localparam int TOKEN_W   = 16;
	localparam int FILL_W    = 7;
	localparam int OUTCOME_W = 3;

	localparam int S_TDATA_W = 16;
	localparam int M_TDATA_W = 40;

	// Register indexes on the configuration port
	localparam logic CFG_BUCKET_SIZE = 1'b0;
	localparam logic CFG_QUEUE_LIMIT = 1'b1;

	localparam logic [TOKEN_W-1:0] BUCKET_SIZE_RST = 16'd16;
	localparam logic [FILL_W-1:0]  QUEUE_LIMIT_RST = 7'd64;

	typedef enum logic [MODE_W-1:0] {
		MODE_TICK   = 1'b0,
		MODE_PACKET = 1'b1
	} mode_t;

	typedef enum logic [OUTCOME_W-1:0] {
		OUT_FORWARDED     = 3'd0,
		OUT_QUEUED        = 3'd1,
		OUT_DROPPED       = 3'd2,
		OUT_TICK_IDLE     = 3'd3,
		OUT_TICK_RELEASED = 3'd4
	} outcome_t;

	// Queue request from the shaper control to the tag queue
	typedef struct packed {
		logic             push;
		logic             pop;
		logic [TAG_W-1:0] tag;
	} queue_req_t;

endpackage

// File: rtl/tbs_ram.sv
module tbs_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 64
) (
	input  logic                                   clk,
	input  logic                                   we,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                       wdata,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                       rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// File: rtl/tbs_queue.sv
module tbs_queue #(
	parameter int DEPTH    = 64,
	parameter int TAG_BITS = 16
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  tbs_pkg::queue_req_t                req,
	output logic [tbs_pkg::TAG_W-1:0]          head_tag,
	output logic [tbs_pkg::FILL_W-1:0]         fill
);
	import tbs_pkg::*;

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int SW = (TAG_BITS < TAG_W) ? TAG_BITS : TAG_W;
	localparam logic [AW-1:0] LAST_SLOT = AW'(DEPTH - 1);

	logic [AW-1:0]     head_q, tail_q, head_d, tail_d;
	logic [FILL_W-1:0] fill_q;
	logic [SW-1:0]     rdata;
	logic              byp_q;
	logic [SW-1:0]     byp_data_q;

	always_comb begin
		head_d = head_q;
		tail_d = tail_q;
		if (req.pop) begin
			head_d = (head_q == LAST_SLOT) ? '0 : head_q + AW'(1);
		end
		if (req.push) begin
			tail_d = (tail_q == LAST_SLOT) ? '0 : tail_q + AW'(1);
		end
	end

	// Read address is the next head pointer so the head entry is on rdata, but for a push into that slot
	tbs_ram #(
		.WIDTH(SW),
		.DEPTH(DEPTH)
	) u_ram (
		.clk   (clk),
		.we    (req.push),
		.waddr (tail_q),
		.wdata (req.tag[SW-1:0]),
		.raddr (head_d),
		.rdata (rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q <= '0;
			tail_q <= '0;
			fill_q <= '0;
			byp_q  <= 1'b0;
		end else begin
			head_q <= head_d;
			tail_q <= tail_d;
			if (req.push && !req.pop) begin
				fill_q <= fill_q + FILL_W'(1);
			end else if (req.pop && !req.push) begin
				fill_q <= fill_q - FILL_W'(1);
			end
			// write into the slot being read this cycle: RAM returns stale data
			byp_q <= req.push && (tail_q == head_d);
		end
	end

	always_ff @(posedge clk) begin
		byp_data_q <= req.tag[SW-1:0];
	end

	assign head_tag = TAG_W'(byp_q ? byp_data_q : rdata);
	assign fill     = fill_q;

	a_no_pop_empty: assert property (@(posedge clk) disable iff (!arst_n)
		req.pop |-> fill_q != '0)
		else $error("pop from empty tag queue");

	a_no_push_full: assert property (@(posedge clk) disable iff (!arst_n)
		req.push |-> 32'(fill_q) < DEPTH)
		else $error("push into full tag queue");

	a_fill_tracks: assert property (@(posedge clk) disable iff (!arst_n)
		req.push && !req.pop |=> fill_q == $past(fill_q) + FILL_W'(1))
		else $error("fill count did not follow push");

endmodule

// File: rtl/token_bucket_shaper_unit.sv
// Token bucket shaper.
// Input stream (s_*): one beat is either a token tick (s_tuser = 0) or a
// packet arrival (s_tuser = 1) carrying its tag in s_tdata.
// Output stream (m_*): exactly one result beat per input beat, in order.
// m_tuser holds the outcome; m_tdata holds sent tag, token count and queue
// fill after the step.
// Configuration: cfg_we/cfg_index/cfg_wdata writes bucket_size (index 0,
// which also refills the bucket) or queue_limit (index 1). Write only while
// no beat is in flight.
// A beat waits in the input register (s1); its result is registered when
// s1 advances, which m_tready can stall. Throughput: one beat per cycle
// unless stalled; each step is one queue access and one token update. The
// tag RAM prefetches the queue head, so back-to-back releases need no wait.
// Reset: bucket full at 16 tokens, queue_limit 64, queue empty. No clearing
// pass; queue entries are only read after being written.
// Stall: while m_tready is low the result holds, and one further beat is
// taken into the input register before s_tready falls.
module token_bucket_shaper_unit #(
	parameter int QUEUE_DEPTH = 64,
	parameter int TAG_BITS    = 16
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              s_tvalid,
	output logic                              s_tready,
	input  logic [tbs_pkg::S_TDATA_W-1:0]     s_tdata,  // [15:0] packet_tag
	input  logic [tbs_pkg::MODE_W-1:0]        s_tuser,  // [0] mode
	output logic                              m_tvalid,
	input  logic                              m_tready,
	// [15:0] sent_tag, [31:16] tokens_now, [38:32] waiting_count, [39] zero
	output logic [tbs_pkg::M_TDATA_W-1:0]     m_tdata,
	output logic [tbs_pkg::OUTCOME_W-1:0]     m_tuser,  // [2:0] outcome
	input  logic                              cfg_we,
	input  logic                              cfg_index,
	input  logic [tbs_pkg::TOKEN_W-1:0]       cfg_wdata
);
	import tbs_pkg::*;

	localparam int SW = (TAG_BITS < TAG_W) ? TAG_BITS : TAG_W;

	logic [TOKEN_W-1:0] bucket_q, tokens_q, tokens_d, tok_inc;
	logic [FILL_W-1:0]  limit_q, eff_limit, fill;
	logic [TAG_W-1:0]   head_tag;

	logic               s1_valid;
	mode_t              s1_mode;
	logic [TAG_W-1:0]   s1_tag;

	logic               advance;
	outcome_t           outcome_d;
	logic [TAG_W-1:0]   sent_d;
	queue_req_t         qreq;

	logic               out_valid_q;
	outcome_t           out_outcome_q;
	logic [TAG_W-1:0]   out_sent_q;
	logic [TOKEN_W-1:0] out_tokens_q;
	logic [FILL_W-1:0]  out_fill_q;

	assign advance  = s1_valid && (!out_valid_q || m_tready);
	assign s_tready = !s1_valid || advance;

	assign eff_limit = ({25'b0, limit_q} > 32'(QUEUE_DEPTH)) ? FILL_W'(QUEUE_DEPTH) : limit_q;
	assign tok_inc   = (tokens_q < bucket_q) ? tokens_q + TOKEN_W'(1) : tokens_q;

	always_comb begin
		tokens_d  = tokens_q;
		outcome_d = OUT_TICK_IDLE;
		sent_d    = '0;
		qreq.push = 1'b0;
		qreq.pop  = 1'b0;
		qreq.tag  = s1_tag;
		unique case (s1_mode)
			MODE_TICK: begin
				tokens_d = tok_inc;
				if (fill != '0 && tok_inc != '0) begin
					tokens_d  = tok_inc - TOKEN_W'(1);
					qreq.pop  = advance;
					sent_d    = head_tag;
					outcome_d = OUT_TICK_RELEASED;
				end
			end
			MODE_PACKET: begin
				priority if (tokens_q != '0 && fill == '0) begin
					tokens_d  = tokens_q - TOKEN_W'(1);
					sent_d    = s1_tag;
					outcome_d = OUT_FORWARDED;
				end else if (fill < eff_limit) begin
					qreq.push = advance;
					outcome_d = OUT_QUEUED;
				end else begin
					outcome_d = OUT_DROPPED;
				end
			end
			default: ;
		endcase
	end

	tbs_queue #(
		.DEPTH    (QUEUE_DEPTH),
		.TAG_BITS (TAG_BITS)
	) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.req      (qreq),
		.head_tag (head_tag),
		.fill     (fill)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bucket_q    <= BUCKET_SIZE_RST;
			tokens_q    <= BUCKET_SIZE_RST;
			limit_q     <= QUEUE_LIMIT_RST;
			s1_valid    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				unique case (cfg_index)
					CFG_BUCKET_SIZE: begin
						bucket_q <= cfg_wdata;
						tokens_q <= cfg_wdata;
					end
					CFG_QUEUE_LIMIT: limit_q <= cfg_wdata[FILL_W-1:0];
					default: ;
				endcase
			end else if (advance) begin
				tokens_q <= tokens_d;
			end
			if (s_tready) begin
				s1_valid <= s_tvalid;
			end
			if (advance) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			s1_mode <= mode_t'(s_tuser);
			s1_tag  <= TAG_W'(s_tdata[SW-1:0]);
		end
		if (advance) begin
			out_outcome_q <= outcome_d;
			out_sent_q    <= sent_d;
			out_tokens_q  <= tokens_d;
			out_fill_q    <= fill + FILL_W'(qreq.push) - FILL_W'(qreq.pop);
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tuser  = out_outcome_q;
	assign m_tdata  = {1'b0, out_fill_q, out_tokens_q, out_sent_q};

	a_tokens_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		tokens_q <= bucket_q)
		else $error("token count above bucket size");

	a_fwd_queue_empty: assert property (@(posedge clk) disable iff (!arst_n)
		advance && outcome_d == OUT_FORWARDED |-> fill == '0 && !qreq.push)
		else $error("packet forwarded past waiting packets");

	a_result_follows: assert property (@(posedge clk) disable iff (!arst_n)
		advance |=> out_valid_q && out_tokens_q == tokens_q)
		else $error("result register does not match token state");

endmodule

// File: verif/token_bucket_shaper_unit_tb.sv
`timescale 1ns / 1ps

module token_bucket_shaper_unit_tb;

	import tbs_pkg::*;

	localparam int SLOTS      = 64;
	localparam int LONG_HOLD  = 300;
	localparam int PAD_LO     = TAG_W + TOKEN_W + FILL_W;

	typedef struct {
		mode_t            mode;
		logic [TAG_W-1:0] tag;
	} shaper_beat_t;

	typedef struct packed {
		outcome_t           outcome;
		logic [TAG_W-1:0]   sent_tag;
		logic [TOKEN_W-1:0] tokens;
		logic [FILL_W-1:0]  fill;
	} shaper_result_t;

	logic                 clk       = 1'b0;
	logic                 arst_n    = 1'b0;
	logic                 s_tvalid  = 1'b0;
	logic                 s_tready;
	logic [S_TDATA_W-1:0] s_tdata   = '0;
	logic [MODE_W-1:0]    s_tuser   = '0;
	logic                 m_tvalid;
	logic                 m_tready  = 1'b0;
	logic [M_TDATA_W-1:0] m_tdata;
	logic [OUTCOME_W-1:0] m_tuser;
	logic                 cfg_we    = 1'b0;
	logic                 cfg_index = 1'b0;
	logic [TOKEN_W-1:0]   cfg_wdata = '0;

	// shaper state as the checker sees it
	logic [TOKEN_W-1:0] bucket_size_now = BUCKET_SIZE_RST;
	logic [FILL_W-1:0]  queue_limit_now = QUEUE_LIMIT_RST;
	logic [TOKEN_W-1:0] token_level     = BUCKET_SIZE_RST;
	logic [TAG_W-1:0]   waiting_tags[$];

	shaper_beat_t   beat_queue[$];
	shaper_result_t expected_results[$];

	int  mismatches    = 0;
	int  burst_left    = 1;
	int  gap_left      = 0;
	bit  tx_gaps       = 1'b1;
	int  rx_stalls     = 3;
	int  rx_run        = 0;
	bit  rx_ready      = 1'b1;
	int  hold_left     = 0;
	bit  long_hold_req = 1'b0;

	token_bucket_shaper_unit #(
		.QUEUE_DEPTH(SLOTS),
		.TAG_BITS(TAG_W)
	) uut (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tuser(s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.m_tuser(m_tuser),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_wdata(cfg_wdata)
	);

	always #1 clk = ~clk;

	function automatic shaper_result_t shape_step(input mode_t m, input logic [TAG_W-1:0] tag);
		shaper_result_t r;
		int unsigned    cap;
		r.sent_tag = '0;
		cap = (queue_limit_now > SLOTS) ? SLOTS : queue_limit_now;
		if (m == MODE_TICK) begin
			if (token_level < bucket_size_now)
				token_level++;
			if (waiting_tags.size() > 0 && token_level > 0) begin
				r.sent_tag = waiting_tags.pop_front();
				token_level--;
				r.outcome = OUT_TICK_RELEASED;
			end else begin
				r.outcome = OUT_TICK_IDLE;
			end
		end else if (token_level > 0 && waiting_tags.size() == 0) begin
			token_level--;
			r.sent_tag = tag;
			r.outcome = OUT_FORWARDED;
		end else if (waiting_tags.size() < cap) begin
			waiting_tags.push_back(tag);
			r.outcome = OUT_QUEUED;
		end else begin
			r.outcome = OUT_DROPPED;
		end
		r.tokens = token_level;
		r.fill = FILL_W'(waiting_tags.size());
		return r;
	endfunction

	// sender: holds a beat until taken, bursts split by random gaps if tx_gaps is set
	always @(posedge clk) begin : drive
		shaper_beat_t nxt;
		logic         on_bus;
		if (!arst_n) begin
			s_tvalid <= 1'b0;
		end else begin
			on_bus = s_tvalid;
			if (s_tvalid && s_tready) begin
				expected_results.push_back(shape_step(mode_t'(s_tuser), s_tdata));
				on_bus = 1'b0;
			end
			if (!on_bus) begin
				if (gap_left > 0) begin
					gap_left--;
					s_tvalid <= 1'b0;
				end else if (beat_queue.size() > 0) begin
					nxt = beat_queue.pop_front();
					s_tvalid <= 1'b1;
					s_tuser <= nxt.mode;
					s_tdata <= nxt.tag;
					if (burst_left <= 1) begin
						burst_left = $urandom_range(1, 16);
						gap_left = tx_gaps ? $urandom_range(1, 8) : 0;
					end else begin
						burst_left--;
					end
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	// receiver: ready/stall runs unless rx_stalls is 0, plus one long hold-off on request
	always @(posedge clk) begin : sink
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else if (hold_left > 0) begin
			hold_left--;
			m_tready <= 1'b0;
		end else if (long_hold_req) begin
			long_hold_req = 1'b0;
			hold_left = LONG_HOLD - 1;
			m_tready <= 1'b0;
		end else if (rx_stalls == 0) begin
			m_tready <= 1'b1;
		end else begin
			if (rx_run == 0) begin
				rx_ready = !rx_ready;
				rx_run = rx_ready ? $urandom_range(1, 10) : $urandom_range(1, rx_stalls);
			end
			rx_run--;
			m_tready <= rx_ready;
		end
	end

	always @(posedge clk) begin : watch
		shaper_result_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (expected_results.size() == 0) begin
				$error("unexpected result beat: outcome %0d, tdata %h", m_tuser, m_tdata);
				mismatches++;
			end else begin
				want = expected_results.pop_front();
				if (m_tuser !== want.outcome) begin
					$error("outcome: expected %0d, got %0d", want.outcome, m_tuser);
					mismatches++;
				end
				if (m_tdata[TAG_W-1:0] !== want.sent_tag) begin
					$error("sent_tag: expected %h, got %h", want.sent_tag, m_tdata[TAG_W-1:0]);
					mismatches++;
				end
				if (m_tdata[TAG_W+TOKEN_W-1:TAG_W] !== want.tokens) begin
					$error("tokens_now: expected %0d, got %0d", want.tokens,
						m_tdata[TAG_W+TOKEN_W-1:TAG_W]);
					mismatches++;
				end
				if (m_tdata[PAD_LO-1:TAG_W+TOKEN_W] !== want.fill) begin
					$error("waiting_count: expected %0d, got %0d", want.fill,
						m_tdata[PAD_LO-1:TAG_W+TOKEN_W]);
					mismatches++;
				end
				if (m_tdata[M_TDATA_W-1:PAD_LO] !== '0) begin
					$error("pad: expected 0, got %h", m_tdata[M_TDATA_W-1:PAD_LO]);
					mismatches++;
				end
			end
		end
	end

	task automatic push_beat(input mode_t m, input logic [TAG_W-1:0] tag);
		shaper_beat_t b;
		b.mode = m;
		b.tag = tag;
		beat_queue.push_back(b);
	endtask

	// checked at the falling edge so all rising-edge updates have settled
	task automatic wait_idle();
		do @(negedge clk);
		while (beat_queue.size() != 0 || s_tvalid || expected_results.size() != 0);
		repeat (4) @(negedge clk);
	endtask

	task automatic write_reg(input logic idx, input logic [TOKEN_W-1:0] val);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		if (idx == CFG_BUCKET_SIZE) begin
			bucket_size_now = val;
			token_level = val;
		end else begin
			queue_limit_now = val[FILL_W-1:0];
		end
		@(negedge clk);
	endtask

	task automatic random_beats(input int n, input int tick_pct);
		for (int i = 0; i < n; i++)
			push_beat(($urandom_range(0, 99) < tick_pct) ? MODE_TICK : MODE_PACKET,
				TAG_W'($urandom_range(0, 65535)));
	endtask

	initial begin : stimulus
		logic [TOKEN_W-1:0] bsz;
		logic [FILL_W-1:0]  lim;
		int                 pct;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// reset values: full bucket, saturating tick
		push_beat(MODE_TICK, 16'h0000);
		push_beat(MODE_PACKET, 16'h0000);
		push_beat(MODE_PACKET, 16'hFFFF);
		push_beat(MODE_TICK, 16'hFFFF);
		wait_idle();

		// one token, room for two: forward, queue twice, drop, release twice, idle
		write_reg(CFG_BUCKET_SIZE, 16'd1);
		write_reg(CFG_QUEUE_LIMIT, 16'd2);
		push_beat(MODE_PACKET, 16'h1111);
		push_beat(MODE_PACKET, 16'h2222);
		push_beat(MODE_PACKET, 16'h3333);
		push_beat(MODE_PACKET, 16'h4444);
		push_beat(MODE_TICK, 16'h0000);
		push_beat(MODE_TICK, 16'h0000);
		push_beat(MODE_TICK, 16'h0000);
		wait_idle();

		// empty bucket with no queue room
		write_reg(CFG_BUCKET_SIZE, 16'd0);
		write_reg(CFG_QUEUE_LIMIT, 16'd0);
		push_beat(MODE_PACKET, 16'h5555);
		push_beat(MODE_TICK, 16'h0000);
		wait_idle();

		write_reg(CFG_QUEUE_LIMIT, 16'd3);
		push_beat(MODE_PACKET, 16'hA5A5);
		push_beat(MODE_PACKET, 16'h5A5A);
		push_beat(MODE_PACKET, 16'h8001);
		wait_idle();

		// limit dropped under the current fill
		write_reg(CFG_QUEUE_LIMIT, 16'd1);
		push_beat(MODE_PACKET, 16'h7FFE);
		wait_idle();

		// bucket refilled while packets wait
		write_reg(CFG_BUCKET_SIZE, 16'd2);
		push_beat(MODE_TICK, 16'h0000);
		push_beat(MODE_PACKET, 16'hC3C3);
		push_beat(MODE_TICK, 16'h0000);
		push_beat(MODE_TICK, 16'h0000);
		push_beat(MODE_TICK, 16'h0000);
		wait_idle();

		for (int ph = 0; ph < 12; ph++) begin
			case ($urandom_range(0, 5))
				0: bsz = 16'd0;
				1: bsz = TOKEN_W'($urandom_range(1, 4));
				2: bsz = TOKEN_W'($urandom_range(5, 40));
				3: bsz = 16'hFFFF;
				4: bsz = TOKEN_W'($urandom_range(0, 65535));
				default: bsz = TOKEN_W'($urandom_range(1, 12));
			endcase
			case ($urandom_range(0, 4))
				0: lim = 7'd0;
				1: lim = FILL_W'($urandom_range(1, 8));
				2: lim = 7'd64;
				3: lim = FILL_W'($urandom_range(60, 127));
				default: lim = FILL_W'($urandom_range(0, 127));
			endcase
			pct = 15 + 20 * $urandom_range(0, 3);
			tx_gaps = $urandom_range(0, 2) != 0;
			rx_stalls = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
			if (ph == 0) begin
				// limit above the depth with a dry bucket: fills to depth, then drops
				bsz = 16'd0;
				lim = 7'd127;
				pct = 5;
			end
			if (ph == 0 || ph == 1 || $urandom_range(0, 3) != 0)
				write_reg(CFG_BUCKET_SIZE, bsz);
			if (ph == 0 || $urandom_range(0, 3) != 0)
				write_reg(CFG_QUEUE_LIMIT, {9'($urandom_range(0, 511)), lim});
			if (ph == 1) begin
				// long receiver hold-off while the sender keeps offering
				tx_gaps = 1'b0;
				rx_stalls = 0;
				long_hold_req = 1'b1;
			end
			random_beats(115, pct);
			wait_idle();
		end

		repeat (10) @(posedge clk);
		if (mismatches == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

	initial begin : watchdog
		#1_000_000;
		$display("[FAIL] regression broken");
		$finish;
	end

endmodule
